// ===== hw/rtl/ssm_pkg.sv =====
// Shared types, widths and helpers for the sorted squares merge block.
// Used by the merge, readout, top-level and checker modules under hw/rtl; depends on nothing else.
`default_nettype none

package ssm_pkg;

    // Field widths fixed by the stream format.
    localparam int SAMPLE_W    = 16;
    localparam int MAG_W       = 17;
    localparam int SQ_W        = 31;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    // Top-level sequencing.
    typedef enum logic [1:0] {
        TOP_LOAD,
        TOP_MERGE,
        TOP_EMIT
    } t_top_state;

    // Two-pointer merge sequencer.
    typedef enum logic [1:0] {
        MRG_IDLE,
        MRG_READ,
        MRG_CMP,
        MRG_DRAIN
    } t_mrg_state;

    // Result readout sequencer.
    typedef enum logic [1:0] {
        EMT_IDLE,
        EMT_READ,
        EMT_SHOW
    } t_emt_state;

    // Start pulses from the top-level controller.
    typedef struct packed {
        logic mrg_go;
        logic emt_go;
    } t_ssm_ctl;

    // Completion flags back to the top-level controller.
    typedef struct packed {
        logic mrg_done;
        logic emt_done;
    } t_ssm_sts;

    // Absolute value of a signed sample; -32768 maps to 32768.
    function automatic logic [MAG_W-1:0] sample_mag(input logic [SAMPLE_W-1:0] s);
        logic [MAG_W-1:0] ext;
        begin
            ext = {s[SAMPLE_W-1], s};
            sample_mag = s[SAMPLE_W-1] ? (~ext + MAG_W'(1)) : ext;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ssm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; instantiated for the sample and square stores.
`default_nettype none

module ssm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ssm_merge.sv =====
// Two-pointer merge: walks inward over the sample store, squares the larger
// magnitude and writes it into the square store from the top down. Uses ssm_pkg.
`default_nettype none

module ssm_merge #(
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_go,
    input  wire logic [CW-1:0]                i_count,
    output logic      [AW-1:0]                o_left_addr,
    output logic      [AW-1:0]                o_right_addr,
    input  wire logic [ssm_pkg::SAMPLE_W-1:0] i_left_data,
    input  wire logic [ssm_pkg::SAMPLE_W-1:0] i_right_data,
    output logic                              o_sq_we,
    output logic      [AW-1:0]                o_sq_addr,
    output logic      [ssm_pkg::SQ_W-1:0]     o_sq_data,
    output logic                              o_done
);

    ssm_pkg::t_mrg_state r_state, n_state;

    logic [AW-1:0]               r_left, r_right;
    logic [CW-1:0]               r_rem;
    logic [ssm_pkg::MAG_W-1:0]   r_mag;
    logic [AW-1:0]               r_mag_addr;
    logic                        r_mag_vld;
    logic [ssm_pkg::SQ_W-1:0]    r_sq;
    logic [AW-1:0]               r_sq_addr;
    logic                        r_sq_vld;

    logic [ssm_pkg::MAG_W-1:0]   mag_l, mag_r;
    logic                        take_right;
    logic [2*ssm_pkg::MAG_W-1:0] prod;
    logic                        step_en;
    logic                        drained;

    // Magnitude compare on the registered read data; ties take the left.
    assign mag_l      = ssm_pkg::sample_mag(i_left_data);
    assign mag_r      = ssm_pkg::sample_mag(i_right_data);
    assign take_right = (mag_l < mag_r);
    assign drained    = !r_mag_vld && !r_sq_vld;
    assign prod       = r_mag * r_mag;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ssm_pkg::MRG_IDLE:  if (i_go) n_state = ssm_pkg::MRG_READ;
            ssm_pkg::MRG_READ:  n_state = ssm_pkg::MRG_CMP;
            ssm_pkg::MRG_CMP:   n_state = (r_rem == CW'(1)) ? ssm_pkg::MRG_DRAIN
                                                            : ssm_pkg::MRG_READ;
            ssm_pkg::MRG_DRAIN: if (drained) n_state = ssm_pkg::MRG_IDLE;
            default:            n_state = ssm_pkg::MRG_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        step_en = 1'b0;
        o_done  = 1'b0;
        case (r_state)
            ssm_pkg::MRG_CMP:   step_en = 1'b1;
            ssm_pkg::MRG_DRAIN: o_done  = drained;
            default: begin
                step_en = 1'b0;
                o_done  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ssm_pkg::MRG_IDLE;
            r_mag_vld <= 1'b0;
            r_sq_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mag_vld <= step_en;
            r_sq_vld  <= r_mag_vld;
        end
    end

    // Pointer walk: the left pointer moves up, the right one down, one per step.
    always_ff @(posedge i_clk) begin
        if (r_state == ssm_pkg::MRG_IDLE && i_go) begin
            r_left  <= '0;
            r_right <= AW'(i_count - CW'(1));
            r_rem   <= i_count;
        end else if (step_en) begin
            r_rem <= r_rem - CW'(1);
            if (take_right) begin
                if (r_right != '0) begin
                    r_right <= r_right - AW'(1);
                end
            end else begin
                r_left <= r_left + AW'(1);
            end
        end
    end

    // Chosen magnitude, then its square, each behind a register.
    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_mag      <= take_right ? mag_r : mag_l;
            r_mag_addr <= AW'(r_rem - CW'(1));
        end
        r_sq      <= prod[ssm_pkg::SQ_W-1:0];
        r_sq_addr <= r_mag_addr;
    end

    assign o_left_addr  = r_left;
    assign o_right_addr = r_right;
    assign o_sq_we      = r_sq_vld;
    assign o_sq_addr    = r_sq_addr;
    assign o_sq_data    = r_sq;

endmodule

`default_nettype wire

// ===== hw/rtl/ssm_emit.sv =====
// Result readout: reads the square store from the bottom up and presents each
// square on the output stream. Uses ssm_pkg.
`default_nettype none

module ssm_emit #(
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_go,
    input  wire logic [CW-1:0]                   i_count,
    input  wire logic                            i_overflow,
    output logic      [AW-1:0]                   o_rd_addr,
    input  wire logic [ssm_pkg::SQ_W-1:0]        i_rd_data,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [ssm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                                 m_axis_tlast,
    output logic                                 m_axis_tuser,
    output logic                                 o_done
);

    ssm_pkg::t_emt_state r_state, n_state;
    logic [CW-1:0]       r_idx;
    logic                is_final;
    logic                take;

    assign is_final = (r_idx == i_count - CW'(1));
    assign take     = m_axis_tvalid && m_axis_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ssm_pkg::EMT_IDLE: if (i_go) n_state = ssm_pkg::EMT_READ;
            ssm_pkg::EMT_READ: n_state = ssm_pkg::EMT_SHOW;
            ssm_pkg::EMT_SHOW: begin
                if (take) begin
                    n_state = is_final ? ssm_pkg::EMT_IDLE : ssm_pkg::EMT_READ;
                end
            end
            default:           n_state = ssm_pkg::EMT_IDLE;
        endcase
    end

    // State outputs: the item is shown while the read data register holds it.
    always_comb begin
        m_axis_tvalid = 1'b0;
        o_done        = 1'b0;
        case (r_state)
            ssm_pkg::EMT_SHOW: begin
                m_axis_tvalid = 1'b1;
                o_done        = m_axis_tready && is_final;
            end
            default: begin
                m_axis_tvalid = 1'b0;
                o_done        = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssm_pkg::EMT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Read index counts up from the bottom of the store.
    always_ff @(posedge i_clk) begin
        if (r_state == ssm_pkg::EMT_IDLE && i_go) begin
            r_idx <= '0;
        end else if (r_state == ssm_pkg::EMT_SHOW && take) begin
            r_idx <= r_idx + CW'(1);
        end
    end

    assign o_rd_addr    = r_idx[AW-1:0];
    assign m_axis_tdata = {{(ssm_pkg::OUT_TDATA_W - ssm_pkg::SQ_W){1'b0}}, i_rd_data};
    assign m_axis_tlast = is_final;
    assign m_axis_tuser = i_overflow;

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_squares_merge_top.sv =====
// Top level of the sorted squares merge block: load control, stores and sequencing.
// Depends on ssm_pkg, ssm_ram, ssm_merge and ssm_emit.
//
//   channel  | dir | tdata                      | tlast       | tuser
//   s_axis   | in  | [15:0] value (signed)      | is_last     | -
//   m_axis   | out | [30:0] square, [31] zero   | end_of_run  | dropped_items
//
// Samples are taken while the block is loading; input is held off from the item
// marked last until the final square of that run has been taken.
// Merging steps through a read state and a compare state for each stored sample,
// set by the registered read of the sample stores, then drains the square pipeline
// and its store write. Readout starts in the cycle after the merge reports done.
// Each square then passes through a square store read state, then a show state.
// Reset is synchronous, active low, and returns the block to loading an empty run.
`default_nettype none

module sorted_squares_merge_top #(
    parameter int DEPTH = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [ssm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] value
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [ssm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [30:0] square, [31] zero
    output logic                                 m_axis_tlast,
    output logic                                 m_axis_tuser   // [0] dropped_items
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ssm_pkg::t_top_state r_state, n_state;
    ssm_pkg::t_ssm_ctl   r_ctl;
    ssm_pkg::t_ssm_sts   sts;

    logic [CW-1:0] r_fill;
    logic          r_ovf;
    logic          in_take;
    logic          has_room;

    logic [AW-1:0]               left_addr, right_addr;
    logic [ssm_pkg::SAMPLE_W-1:0] left_data, right_data;
    logic                        sq_we;
    logic [AW-1:0]               sq_waddr, sq_raddr;
    logic [ssm_pkg::SQ_W-1:0]    sq_wdata, sq_rdata;

    assign in_take  = s_axis_tvalid && s_axis_tready;
    assign has_room = (r_fill < CW'(DEPTH));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ssm_pkg::TOP_LOAD:  if (in_take && s_axis_tlast) n_state = ssm_pkg::TOP_MERGE;
            ssm_pkg::TOP_MERGE: if (sts.mrg_done) n_state = ssm_pkg::TOP_EMIT;
            ssm_pkg::TOP_EMIT:  if (sts.emt_done) n_state = ssm_pkg::TOP_LOAD;
            default:            n_state = ssm_pkg::TOP_LOAD;
        endcase
    end

    // State outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        case (r_state)
            ssm_pkg::TOP_LOAD: s_axis_tready = 1'b1;
            default:           s_axis_tready = 1'b0;
        endcase
    end

    // Control registers: state, start pulses, fill count and overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssm_pkg::TOP_LOAD;
            r_ctl   <= '0;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ctl.mrg_go <= in_take && s_axis_tlast;
            r_ctl.emt_go <= (r_state == ssm_pkg::TOP_MERGE) && sts.mrg_done;
            if (in_take) begin
                if (has_room) begin
                    r_fill <= r_fill + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end else if (sts.emt_done) begin
                r_fill <= '0;
                r_ovf  <= 1'b0;
            end
        end
    end

    // Two copies of the sample store give the left and right reads in the same cycle.
    ssm_ram #(.WIDTH(ssm_pkg::SAMPLE_W), .DEPTH(DEPTH)) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (in_take && has_room),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (s_axis_tdata[ssm_pkg::SAMPLE_W-1:0]),
        .i_raddr (left_addr),
        .o_rdata (left_data)
    );

    ssm_ram #(.WIDTH(ssm_pkg::SAMPLE_W), .DEPTH(DEPTH)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (in_take && has_room),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (s_axis_tdata[ssm_pkg::SAMPLE_W-1:0]),
        .i_raddr (right_addr),
        .o_rdata (right_data)
    );

    // Square store, written by the merge and read by the readout.
    ssm_ram #(.WIDTH(ssm_pkg::SQ_W), .DEPTH(DEPTH)) u_square_ram (
        .i_clk   (i_clk),
        .i_we    (sq_we),
        .i_waddr (sq_waddr),
        .i_wdata (sq_wdata),
        .i_raddr (sq_raddr),
        .o_rdata (sq_rdata)
    );

    ssm_merge #(.DEPTH(DEPTH)) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (r_ctl.mrg_go),
        .i_count      (r_fill),
        .o_left_addr  (left_addr),
        .o_right_addr (right_addr),
        .i_left_data  (left_data),
        .i_right_data (right_data),
        .o_sq_we      (sq_we),
        .o_sq_addr    (sq_waddr),
        .o_sq_data    (sq_wdata),
        .o_done       (sts.mrg_done)
    );

    ssm_emit #(.DEPTH(DEPTH)) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (r_ctl.emt_go),
        .i_count       (r_fill),
        .i_overflow    (r_ovf),
        .o_rd_addr     (sq_raddr),
        .i_rd_data     (sq_rdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .o_done        (sts.emt_done)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ssm_checker.sv =====
// Port-level checks for the sorted squares merge block, bound to its top level.
// Depends on ssm_pkg and sorted_squares_merge_top.
`default_nettype none

module ssm_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            s_axis_tlast,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [ssm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                            m_axis_tlast
);

    // Input is never taken while a result of the run is on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // The item that closes a run stops further input.
    a_close_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still ready after the last item of a run");

    // Taking the final result ends output for that run.
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("result offered after the end of the run");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind sorted_squares_merge_top ssm_checker u_ssm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== tb/sv/tb_sorted_squares_merge_top.sv =====
// Self-checking testbench for sorted_squares_merge_top: drives runs of signed samples
// and compares every emitted square against an in-bench predictor of the two-pointer merge.
// Depends on ssm_pkg and the sorted_squares_merge_top RTL only.
`timescale 1ns / 1ps

module tb_sorted_squares_merge_top;

    localparam int RUN_DEPTH      = 64;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT     = 4000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int ITEM_TARGET    = 250;

    // One expected output item.
    typedef struct packed {
        logic [ssm_pkg::SQ_W-1:0] square;
        logic                     end_of_run;
        logic                     dropped_items;
    } t_square_result;

    // Collects the samples of a run and, on the closing item, works out the squares
    // in the order the block emits them; then checks each emitted item in turn.
    class sorted_square_predictor;
        logic [ssm_pkg::SAMPLE_W-1:0] run_samples [RUN_DEPTH];
        int unsigned                  run_len;
        bit                           run_dropped;
        t_square_result               expected_squares [$];
        int unsigned                  mismatches;

        function logic [ssm_pkg::MAG_W-1:0] magnitude(input logic [ssm_pkg::SAMPLE_W-1:0] s);
            logic signed [ssm_pkg::MAG_W-1:0] wide;
            wide = $signed({s[ssm_pkg::SAMPLE_W-1], s});
            return (wide < 0) ? -wide : wide;
        endfunction

        function void note_sample(input logic [ssm_pkg::SAMPLE_W-1:0] value, input bit last);
            logic [ssm_pkg::SQ_W-1:0]  merged [RUN_DEPTH];
            logic [ssm_pkg::MAG_W-1:0] mag_lo;
            logic [ssm_pkg::MAG_W-1:0] mag_hi;
            logic [2*ssm_pkg::MAG_W-1:0] prod;
            int unsigned lo;
            int unsigned hi;
            int unsigned slot;
            t_square_result item;
            // A full store drops the sample, even the closing one.
            if (run_len < RUN_DEPTH) begin
                run_samples[run_len] = value;
                run_len++;
            end else begin
                run_dropped = 1'b1;
            end
            if (!last)
                return;
            // Walk inward from both ends, larger magnitude first, left wins a tie.
            lo = 0;
            hi = run_len - 1;
            slot = run_len;
            for (int k = 0; k < run_len; k++) begin
                mag_lo = magnitude(run_samples[lo % RUN_DEPTH]);
                mag_hi = magnitude(run_samples[hi % RUN_DEPTH]);
                slot--;
                if (mag_lo < mag_hi) begin
                    prod = mag_hi * mag_hi;
                    if (hi > 0)
                        hi--;
                end else begin
                    prod = mag_lo * mag_lo;
                    lo++;
                end
                merged[slot] = prod[ssm_pkg::SQ_W-1:0];
            end
            // Results leave from the bottom of the store upward.
            for (int k = 0; k < run_len; k++) begin
                item.square        = merged[k];
                item.end_of_run    = (k == run_len - 1);
                item.dropped_items = run_dropped;
                expected_squares   = {expected_squares, item};
            end
            run_len = 0;
            run_dropped = 1'b0;
        endfunction

        function void check_square(input logic [ssm_pkg::OUT_TDATA_W-1:0] tdata,
                                   input logic tlast, input logic tuser);
            t_square_result want;
            if (expected_squares.size() == 0) begin
                mismatches++;
                $display("%0t: square item with none expected: tdata=%0d last=%b dropped=%b",
                         $time, tdata, tlast, tuser);
                return;
            end
            want = expected_squares.pop_front();
            if (tdata !== {1'b0, want.square} || tlast !== want.end_of_run ||
                    tuser !== want.dropped_items) begin
                mismatches++;
                $display("%0t: square mismatch: expected %0d last=%b dropped=%b,",
                         $time, want.square, want.end_of_run, want.dropped_items);
                $display("%0t:   actual %0d last=%b dropped=%b",
                         $time, tdata, tlast, tuser);
            end
        endfunction

        function int unsigned outstanding();
            return expected_squares.size();
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [ssm_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [15:0] value
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [ssm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // [30:0] square, [31] zero
    logic                            m_axis_tlast;
    logic                            m_axis_tuser;        // [0] dropped_items

    sorted_square_predictor sb = new;
    int unsigned            items_sent = 0;
    int unsigned            idle_cycles = 0;
    bit                     tx_burst = 1'b0;
    bit                     rx_hold_req = 1'b0;
    bit                     rx_holding = 1'b0;

    sorted_squares_merge_top #(
        .DEPTH(RUN_DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    // Half the time no gap, otherwise mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Both stream monitors and the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_sample(s_axis_tdata, s_axis_tlast);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_square(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Result side: ready stretches and stalls, plus one long hold on request.
    initial begin
        int unsigned ready_len;
        int unsigned gap;
        wait (i_rst_n);
        forever begin
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                rx_holding = 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_holding = 1'b0;
                rx_hold_req = 1'b0;
            end
            m_axis_tready <= 1'b1;
            ready_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16)
                                                     : $urandom_range(60, 150);
            repeat (ready_len) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Offer one sample and hold it until it is taken.
    task automatic send_sample(input logic [ssm_pkg::SAMPLE_W-1:0] value, input bit last);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        items_sent++;
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every predicted square has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    // A run of random samples, either in non-decreasing order or in no order.
    task automatic send_run(input int len, input bit ordered);
        int cur;
        int step_max;
        logic [ssm_pkg::SAMPLE_W-1:0] v;
        cur = ($urandom_range(0, 7) == 0) ? -32768 : -int'($urandom_range(0, 32768));
        case ($urandom_range(0, 3))
            0: step_max = 2;
            1: step_max = 300;
            2: step_max = 4000;
            default: step_max = 65535 / len + 1;
        endcase
        for (int i = 0; i < len; i++) begin
            if (ordered) begin
                v = cur[ssm_pkg::SAMPLE_W-1:0];
                cur += $urandom_range(0, step_max);
                if (cur > 32767)
                    cur = 32767;
            end else begin
                v = 16'($urandom_range(0, 65535));
            end
            send_sample(v, i == len - 1);
        end
    endtask

    // Stimulus and final verdict.
    initial begin
        int len;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single-sample runs at zero and both extremes.
        send_sample(16'sd0, 1'b1);
        send_sample(-16'sd32768, 1'b1);
        send_sample(16'sd32767, 1'b1);
        // Full signed range in order; the most negative sample has the largest square.
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd32767, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd32767, 1'b1);
        // Equal magnitudes on both ends, so the left sample is taken first.
        send_sample(-16'sd4, 1'b0);
        send_sample(-16'sd4, 1'b0);
        send_sample(16'sd4, 1'b0);
        send_sample(16'sd4, 1'b1);
        // A run out of order: the walk still runs and its output is checked against the predictor.
        send_sample(16'sd9, 1'b0);
        send_sample(-16'sd3, 1'b0);
        send_sample(16'sd12, 1'b0);
        send_sample(-16'sd20, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd7, 1'b1);
        wait_drained();

        // Exactly full, closing sample dropped, and samples dropped before the close.
        send_run(RUN_DEPTH, 1'b1);
        send_run(RUN_DEPTH + 1, 1'b1);
        send_run(RUN_DEPTH + 6, 1'b0);
        wait_drained();

        // Hold off the result side so the block fills up and stalls its input.
        rx_hold_req = 1'b1;
        wait (rx_holding);
        tx_burst = 1'b1;
        send_run(12, 1'b1);
        send_run(6, 1'b1);
        tx_burst = 1'b0;

        // Random runs, mostly short and in order.
        while (items_sent < ITEM_TARGET) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, RUN_DEPTH)
                                              : $urandom_range(1, 12);
            send_run(len, $urandom_range(0, 9) < 8);
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sorted_squares_merge_top.f =====
hw/rtl/ssm_pkg.sv
hw/rtl/ssm_ram.sv
hw/rtl/ssm_merge.sv
hw/rtl/ssm_emit.sv
hw/rtl/sorted_squares_merge_top.sv
hw/rtl/ssm_checker.sv
tb/sv/tb_sorted_squares_merge_top.sv
